>>> design/i2a_pkg.sv
package i2a_pkg;

    localparam int VALUE_WIDTH = 32;

    // decimal digits needed for VALUE_WIDTH bits, floor(w * log10(2)) + 1
    localparam int DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
    localparam int NDIG       = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
    localparam int DIG_BITS   = NDIG * 4;
    localparam int HEX_BITS   = HEX_DIGITS * 4;
    localparam int HEX_SHIFT  = (NDIG - HEX_DIGITS) * 4;
    localparam int NDIG_W     = $clog2(NDIG + 1);
    localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);
    localparam int SUM_W      = (NDIG_W + 1 > 4) ? NDIG_W + 1 : 4;

    localparam logic       OP_DEC     = 1'b0;
    localparam logic       OP_HEX     = 1'b1;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A     = 8'h61;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_NORM = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    function automatic logic [7:0] nibble_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return CHAR_ZERO + {4'd0, nib};
        end
        return CHAR_A + {4'd0, nib} - 8'd10;
    endfunction

endpackage

>>> design/i2a_dabble_step.sv
module i2a_dabble_step
    import i2a_pkg::*;
(
    input  logic [DIG_BITS-1:0] digits_in,
    input  logic                bit_in,
    output logic [DIG_BITS-1:0] digits_out
);

    logic [DIG_BITS-1:0] adj;

    // add 3 to every bcd digit of 5 or more, then shift in the next binary bit
    always_comb begin
        adj = digits_in;
        for (int i = 0; i < NDIG; i++) begin
            if (digits_in[i*4 +: 4] >= 4'd5) begin
                adj[i*4 +: 4] = digits_in[i*4 +: 4] + 4'd3;
            end
        end
        digits_out = {adj[DIG_BITS-2:0], bit_in};
    end

endmodule

>>> design/integer_to_ascii_text_top.sv
// a hex item goes straight to ST_NORM, which drops leading zeros (up to HEX_DIGITS-1), and
// then to ST_EMIT, which loads the first character; a decimal item first passes through
// ST_CONV, shifting each of the VALUE_WIDTH input bits through the single bcd step instance
// then one character per cycle while m_ready is high, up to 11 characters at width 32
// a new item is accepted only in ST_IDLE, once the last character is in the output register
// aresetn is synchronous and active low; it clears the sequencer and the output valid
module integer_to_ascii_text_top
    import i2a_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_op,
    input  logic [VALUE_WIDTH-1:0] s_value,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_char_code,
    output logic [3:0]             m_text_length,
    output logic                   m_last
);

    state_t state_reg, state_next;
    logic [VALUE_WIDTH-1:0] bin_reg, bin_next;
    logic [DIG_BITS-1:0]    dig_reg, dig_next;
    logic [NDIG_W-1:0]      ndig_reg, ndig_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   sign_reg, sign_next;
    logic                   neg_reg, neg_next;
    logic [3:0]             len_reg, len_next;
    logic                   m_valid_reg, m_valid_next;
    logic [7:0]             char_reg, char_next;
    logic [3:0]             olen_reg, olen_next;
    logic                   last_reg, last_next;

    logic                   in_neg;
    logic [VALUE_WIDTH-1:0] in_mag;
    logic [DIG_BITS-1:0]    dabble_out;
    logic [3:0]             top_nib;
    logic                   out_free;
    logic [SUM_W-1:0]       len_sum;

    i2a_dabble_step u_dabble (
        .digits_in  (dig_reg),
        .bit_in     (bin_reg[VALUE_WIDTH-1]),
        .digits_out (dabble_out)
    );

    assign in_neg   = (s_op == OP_DEC) && s_value[VALUE_WIDTH-1];
    assign in_mag   = in_neg ? (~s_value + 1'b1) : s_value;
    assign top_nib  = dig_reg[DIG_BITS-1 -: 4];
    assign out_free = !m_valid_reg || m_ready;
    assign len_sum  = SUM_W'(ndig_reg) + SUM_W'(neg_reg);

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_char_code   = char_reg;
    assign m_text_length = olen_reg;
    assign m_last        = last_reg;

    always_comb begin
        state_next   = state_reg;
        bin_next     = bin_reg;
        dig_next     = dig_reg;
        ndig_next    = ndig_reg;
        cnt_next     = cnt_reg;
        sign_next    = sign_reg;
        neg_next     = neg_reg;
        len_next     = len_reg;
        m_valid_next = m_valid_reg;
        char_next    = char_reg;
        olen_next    = olen_reg;
        last_next    = last_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    neg_next  = in_neg;
                    sign_next = in_neg;
                    bin_next  = in_mag;
                    cnt_next  = CNT_W'(VALUE_WIDTH);
                    if (s_op == OP_HEX) begin
                        // hex digits left aligned so the top nibble is always the msd
                        dig_next   = DIG_BITS'(HEX_BITS'(in_mag)) << HEX_SHIFT;
                        ndig_next  = NDIG_W'(HEX_DIGITS);
                        state_next = ST_NORM;
                    end else begin
                        dig_next   = '0;
                        ndig_next  = NDIG_W'(DEC_DIGITS);
                        state_next = ST_CONV;
                    end
                end
            end
            ST_CONV: begin
                dig_next = dabble_out;
                bin_next = {bin_reg[VALUE_WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM: begin
                // drop leading zeros, keeping at least one digit
                if (ndig_reg > NDIG_W'(1) && top_nib == 4'd0) begin
                    dig_next  = {dig_reg[DIG_BITS-5:0], 4'd0};
                    ndig_next = ndig_reg - 1'b1;
                end else begin
                    len_next   = len_sum[3:0];
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    olen_next    = len_reg;
                    if (sign_reg) begin
                        char_next = CHAR_MINUS;
                        last_next = 1'b0;
                        sign_next = 1'b0;
                    end else begin
                        char_next = nibble_char(top_nib);
                        last_next = (ndig_reg == NDIG_W'(1));
                        dig_next  = {dig_reg[DIG_BITS-5:0], 4'd0};
                        ndig_next = ndig_reg - 1'b1;
                        if (ndig_reg == NDIG_W'(1)) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            sign_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            sign_reg    <= sign_next;
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg  <= bin_next;
        dig_reg  <= dig_next;
        ndig_reg <= ndig_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        len_reg  <= len_next;
        char_reg <= char_next;
        olen_reg <= olen_next;
        last_reg <= last_next;
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> (state_reg == ST_CONV || state_reg == ST_NORM))
        else $error("accepted item did not start a conversion");

    a_conv_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CONV) |-> (cnt_reg != '0))
        else $error("conversion running with zero bit count");

    a_emit_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (ndig_reg != '0))
        else $error("emitting with no digits left");

    a_char_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_char_code >= 8'h30 && m_char_code <= 8'h39)
                  || (m_char_code >= 8'h61 && m_char_code <= 8'h66)
                  || (m_char_code == CHAR_MINUS && !m_last)))
        else $error("bad output character");
`endif

endmodule
